FILE: rtl/core/cdf_table_build_and_search_assert.svh
// Assertion macros for the cumulative weight table checks.
// Needs nothing else; taken in by the checker with `include.
`ifndef CDF_TABLE_BUILD_AND_SEARCH_ASSERT_SVH
`define CDF_TABLE_BUILD_AND_SEARCH_ASSERT_SVH

// consequent in the same cycle as the antecedent
`define CDFT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdft: same-cycle check failed");

// consequent in the cycle after the antecedent
`define CDFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdft: next-cycle check failed");

`endif

FILE: rtl/core/cdft_pkg.sv
// Shared types and constants for the cumulative weight table.
// No dependencies.
package cdft_pkg;

   localparam int DEF_TABLE_DEPTH = 1024;
   localparam int IDX_W           = 11;
   localparam int START_W         = 10;
   localparam int WEIGHT_W        = 24;
   localparam int SUM_W           = 32;
   localparam int STATUS_W        = 2;

   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic                kind;
      logic [WEIGHT_W-1:0] weight;
      logic                segment_restart;
      logic [START_W-1:0]  segment_start;
      logic [IDX_W-1:0]    segment_count;
      logic [SUM_W-1:0]    probe;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]    found_index;
      logic [SUM_W-1:0]    cumulative;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

FILE: rtl/core/cdf_table_build_and_search.sv
// Top level of the cumulative weight table: append and upper-bound search.
// Depends on cdft_pkg and cdft_store.
//
//   channel   direction  payload            accepted when
//   req_      in         cdft_pkg::req_type req_valid && !req_stall
//   rsp_      out        cdft_pkg::rsp_type rsp_valid && !rsp_stall
//
// One transaction in flight. An append writes at accept, then its result goes
// through ST_FINISH to the output register. A search runs one halving step
// per ST_READ/ST_CMP pair: each step waits on the memory read port.
// Reset clears fill level, running sum and control; table contents stay
// unknown until written. A waiting result sits in the output register, so a
// stalled rsp_ side delays only the next transaction's result hand-off.
module cdf_table_build_and_search #(
   parameter int TABLE_DEPTH = cdft_pkg::DEF_TABLE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cdft_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cdft_pkg::rsp_type rsp_data
);

   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W  = cdft_pkg::IDX_W;
   localparam int SUM_W  = cdft_pkg::SUM_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [FILL_W-1:0] fill_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [IDX_W-1:0]  lo_ff;
   logic [IDX_W-1:0]  hi_ff;
   logic [IDX_W-1:0]  mid_ff;
   logic [SUM_W-1:0]  probe_ff;
   cdft_pkg::rsp_type res_ff;
   logic              rsp_valid_ff;
   cdft_pkg::rsp_type rsp_data_ff;

   logic                    accept;
   logic                    full;
   logic [SUM_W:0]          sum_add;
   logic [SUM_W:0]          sum_total;
   logic [SUM_W-1:0]        sum_in;
   logic [FILL_W+IDX_W-1:0] fill_ext;
   logic [IDX_W-1:0]        fill_idx;
   logic [IDX_W-1:0]        seg_end;
   logic                    range_bad;
   logic [IDX_W-1:0]        mid;
   logic [ADDR_W+IDX_W-1:0] mid_ext;
   logic [IDX_W-1:0]        lo_in;
   logic [IDX_W-1:0]        hi_in;
   logic [SUM_W-1:0]        rd_data;
   logic                    wr_en;
   logic                    rd_en;
   logic                    out_free;
   logic                    rsp_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == ST_FINISH) && out_free;

   // append path
   assign full      = (fill_ff == FILL_W'(TABLE_DEPTH));
   assign sum_add   = {1'b0, sum_ff}
                    + {{(SUM_W + 1 - cdft_pkg::WEIGHT_W){1'b0}}, req_data.weight};
   assign sum_total = req_data.segment_restart
                    ? {{(SUM_W + 1 - cdft_pkg::WEIGHT_W){1'b0}}, req_data.weight}
                    : sum_add;
   assign sum_in    = sum_total[SUM_W] ? {SUM_W{1'b1}} : sum_total[SUM_W-1:0];
   assign fill_ext  = {{IDX_W{1'b0}}, fill_ff};
   assign fill_idx  = fill_ext[IDX_W-1:0];
   assign wr_en     = accept && (req_data.kind == cdft_pkg::KIND_APPEND) && !full;

   // search path: start + count can need 12 bits; seg_end keeps only the low 11
   assign seg_end   = {1'b0, req_data.segment_start} + req_data.segment_count;
   assign range_bad = {{(32 - IDX_W){1'b0}}, seg_end} > 32'(TABLE_DEPTH);
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign mid_ext   = {{ADDR_W{1'b0}}, mid};
   assign rd_en     = (state_ff == ST_READ);

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (probe_ff >= rd_data) begin
         lo_in = mid_ff + IDX_W'(1);
      end else begin
         hi_in = mid_ff;
      end
   end

   cdft_store #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (sum_in),
      .rd_en   (rd_en),
      .rd_addr (mid_ext[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_data.kind == cdft_pkg::KIND_APPEND) begin
                     res_ff.found_index <= fill_idx;
                     if (full) begin
                        res_ff.status     <= cdft_pkg::STATUS_FULL;
                        res_ff.cumulative <= '0;
                     end else begin
                        res_ff.status     <= cdft_pkg::STATUS_OK;
                        res_ff.cumulative <= sum_in;
                        sum_ff            <= sum_in;
                        fill_ff           <= fill_ff + FILL_W'(1);
                     end
                     state_ff <= ST_FINISH;
                  end else if (range_bad) begin
                     res_ff.found_index <= '0;
                     res_ff.cumulative  <= '0;
                     res_ff.status      <= cdft_pkg::STATUS_RANGE;
                     state_ff           <= ST_FINISH;
                  end else begin
                     lo_ff              <= {1'b0, req_data.segment_start};
                     hi_ff              <= seg_end;
                     probe_ff           <= req_data.probe;
                     res_ff.found_index <= {1'b0, req_data.segment_start};
                     res_ff.cumulative  <= '0;
                     res_ff.status      <= cdft_pkg::STATUS_OK;
                     // empty segment answers with its start
                     state_ff <= (req_data.segment_count == '0) ? ST_FINISH : ST_READ;
                  end
               end
            end
            ST_READ: begin
               mid_ff   <= mid;
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               lo_ff              <= lo_in;
               hi_ff              <= hi_in;
               res_ff.found_index <= lo_in;
               state_ff           <= (lo_in < hi_in) ? ST_READ : ST_FINISH;
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_data_ff <= res_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/cdft_store.sv
// Single-port-write, single-port-read table memory with a registered read.
// Depends on cdft_pkg for the entry width.
module cdft_store #(
   parameter int DEPTH  = cdft_pkg::DEF_TABLE_DEPTH,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [cdft_pkg::SUM_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [cdft_pkg::SUM_W-1:0] rd_data
);

   logic [cdft_pkg::SUM_W-1:0] mem [DEPTH];
   logic [cdft_pkg::SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/cdft_checker.sv
// Port-level checks for the cumulative weight table, bound to the top level.
// Depends on cdft_pkg and cdf_table_build_and_search_assert.svh.
`include "cdf_table_build_and_search_assert.svh"

module cdft_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input cdft_pkg::rsp_type rsp_data
);

   `CDFT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // only one transaction is worked on at a time
   `CDFT_ASSERT_NEXT(a_single_flight, clock, reset, req_valid && !req_stall, req_stall)

   `CDFT_ASSERT_NOW(a_range_result, clock, reset, rsp_valid && rsp_data.status == cdft_pkg::STATUS_RANGE, rsp_data.found_index == '0 && rsp_data.cumulative == '0)

   `CDFT_ASSERT_NOW(a_full_result, clock, reset, rsp_valid && rsp_data.status == cdft_pkg::STATUS_FULL, rsp_data.cumulative == '0)

endmodule

bind cdf_table_build_and_search cdft_checker u_cdft_checker (.*);
